@@ rtl/nalsc_pkg.sv @@
// Shared types and constants of the Annex B start-code splitter.
// Holds the result record and field widths used by the top level and the result queue.
// No dependencies.
`timescale 1ns / 1ps

package nalsc_pkg;

  // Counter and field widths
  localparam int unsigned LenBits  = 24;
  localparam int unsigned UnitLenW = 24;
  localparam int unsigned MaxOut   = 5;
  localparam int unsigned CntW     = 3;
  localparam int unsigned DataW    = 40;
  localparam int unsigned PadW     = DataW - (8 + 1 + 5 + UnitLenW + 1);

  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  // Byte and unit type codes
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] StartByte = 8'h01;
  localparam logic [4:0] SeiType   = 5'h06;

  typedef enum logic {
    KindPayload = 1'b0,
    KindEnd     = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          payload_byte;
    logic                first_of_unit;
    logic [4:0]          unit_type;
    logic [UnitLenW-1:0] unit_length;
    logic                length_saturated;
    logic                last_of_run;
  } result_t;

endpackage

@@ rtl/nalsc_out_queue.sv @@
// Result queue of the start-code splitter: holds the results of one request
// and presents them one per cycle while the receiver takes them. Depends on nalsc_pkg.
`timescale 1ns / 1ps

module nalsc_out_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic [nalsc_pkg::CntW-1:0]             load_cnt_i,
  input  nalsc_pkg::result_t [nalsc_pkg::MaxOut-1:0] load_res_i,
  input  logic                                   take_i,
  output nalsc_pkg::result_t                     head_o,
  output logic                                   valid_o,
  output logic                                   can_load_o
);
  import nalsc_pkg::*;

  result_t [MaxOut-1:0] ent_q;
  logic [CntW-1:0]      cnt_q;

  // Free once empty, or once the final entry leaves this cycle
  assign can_load_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && take_i);
  assign valid_o    = (cnt_q != '0);
  assign head_o     = ent_q[0];

  // Track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= load_cnt_i;
    end else if (take_i && valid_o) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Load a new run or advance towards the head
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= load_res_i;
    end else if (take_i && valid_o) begin
      for (int i = 0; i < MaxOut - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

@@ rtl/nal_unit_start_code_splitter_core.sv @@
// Top level of the H.264 Annex B start-code splitter.
// Depends on nalsc_pkg and nalsc_out_queue.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: one stream byte per request in s_axis_tdata, s_axis_tlast
//   marks the final byte (held zeros are flushed and the open unit closed).
//   Master stream: one result per request. tuser is the kind (payload byte
//   or end-of-unit marker), tlast marks the last result caused by one input
//   byte. Bytes before the first start code and, with cfg_wdata_i = 1 (the
//   reset value), SEI units are dropped.
//   Config: cfg_we_i writes the SEI drop flag; write only while idle.
// Timing:
//   An input byte is decoded in the cycle it is accepted and its results are
//   registered, so the first result appears in the cycle after acceptance.
//   One input byte yields 0 to 5 results; the result queue hands them out one
//   per cycle while the receiver takes them. Typical streams give one result
//   per byte and then run at one byte per cycle while the receiver is ready.
// Reset and stall:
//   Reset empties the queue, closes any unit and sets the SEI drop flag.
//   While the receiver stalls, the head result holds and s_axis_tready stays
//   low; the next byte is taken in the cycle the final queued result leaves.
module nal_unit_start_code_splitter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,   // drop_sei_units
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] stream_byte
  input  logic                        s_axis_tlast,  // end_of_stream
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] payload_byte, [8] first_of_unit, [13:9] unit_type,
  // [37:14] unit_length, [38] length_saturated, [39] zero fill
  output logic [nalsc_pkg::DataW-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,  // result_kind
  output logic                        m_axis_tlast   // last_of_run
);
  import nalsc_pkg::*;

  // Parser state
  logic               drop_sei_q;
  logic [1:0]         hz_q, hz_d;
  logic               open_q, open_d;
  logic               await_q, await_d;
  logic [4:0]         type_q, type_d;
  logic               drop_q, drop_d;
  logic [LenBits-1:0] len_q, len_d;
  logic               ovf_q, ovf_d;

  logic                 in_acc;
  logic                 is_zero, is_start, eos;
  logic [7:0]           in_byte;
  logic [CntW-1:0]      np, npe, nres;
  logic                 pre_mark, eos_mark, hdr;
  logic [LenBits:0]     len_sum;
  result_t [MaxOut-1:0] res;
  result_t              head;
  logic                 q_valid, q_can_load;

  assign in_byte       = s_axis_tdata;
  assign eos           = s_axis_tlast;
  assign s_axis_tready = q_can_load;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_zero       = (in_byte == ZeroByte);
  assign is_start      = (in_byte == StartByte) && (hz_q >= 2'd2);

  // Decode one byte: start code, held zeros, payload, end of stream
  always_comb begin
    hz_d     = hz_q;
    open_d   = open_q;
    await_d  = await_q;
    type_d   = type_q;
    drop_d   = drop_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    np       = '0;
    pre_mark = 1'b0;
    hdr      = 1'b0;
    len_sum  = '0;

    // Held zero bookkeeping and start-code detection
    if (is_zero) begin
      if (hz_q != 2'd3) begin
        hz_d = hz_q + 2'd1;
      end else begin
        np = CntW'(1);
      end
    end else if (is_start) begin
      hz_d     = '0;
      pre_mark = open_q && !await_q && !drop_q;
      open_d   = 1'b1;
      await_d  = 1'b1;
      drop_d   = 1'b0;
      len_d    = '0;
      ovf_d    = 1'b0;
    end else begin
      np   = CntW'(hz_q) + CntW'(1);
      hz_d = '0;
    end

    // Flush held zeros at end of stream
    if (eos) begin
      np   = np + CntW'(hz_d);
      hz_d = '0;
    end

    // Count payload into the open unit, take the header if due
    if (open_d && (np != '0)) begin
      if (await_d) begin
        hdr     = 1'b1;
        type_d  = (np == CntW'(1)) ? in_byte[4:0] : 5'd0;
        drop_d  = drop_sei_q && (type_d == SeiType);
        await_d = 1'b0;
      end
      len_sum = {1'b0, len_d} + (LenBits+1)'(np);
      if (len_sum > {1'b0, LenMax}) begin
        len_d = LenMax;
        ovf_d = 1'b1;
      end else begin
        len_d = len_sum[LenBits-1:0];
      end
    end

    npe      = (open_d && !drop_d) ? np : '0;
    eos_mark = eos && open_d && !await_d && !drop_d;
    nres     = pre_mark ? CntW'(1) : (npe + CntW'(eos_mark));

    // Build the run of results in order
    for (int i = 0; i < MaxOut; i++) begin
      res[i] = '0;
      if (pre_mark) begin
        if (i == 0) begin
          res[i].kind             = KindEnd;
          res[i].unit_type        = type_q;
          res[i].unit_length      = UnitLenW'(len_q);
          res[i].length_saturated = ovf_q;
        end
      end else if (CntW'(i) < npe) begin
        res[i].kind          = KindPayload;
        res[i].payload_byte  = (CntW'(i) == np - CntW'(1)) ? in_byte : ZeroByte;
        res[i].first_of_unit = hdr && (i == 0);
        res[i].unit_type     = type_d;
      end else if ((CntW'(i) == npe) && eos_mark) begin
        res[i].kind             = KindEnd;
        res[i].unit_type        = type_d;
        res[i].unit_length      = UnitLenW'(len_d);
        res[i].length_saturated = ovf_d;
      end
      res[i].last_of_run = (CntW'(i) + CntW'(1) == nres);
    end

    // Close the unit at end of stream
    if (eos) begin
      open_d  = 1'b0;
      await_d = 1'b0;
      drop_d  = 1'b0;
      len_d   = '0;
      ovf_d   = 1'b0;
    end
  end

  // Hold the configuration flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_sei_q <= 1'b1;
    end else if (cfg_we_i) begin
      drop_sei_q <= cfg_wdata_i;
    end
  end

  // Advance parser state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz_q    <= '0;
      open_q  <= 1'b0;
      await_q <= 1'b0;
      type_q  <= '0;
      drop_q  <= 1'b0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (in_acc) begin
      hz_q    <= hz_d;
      open_q  <= open_d;
      await_q <= await_d;
      type_q  <= type_d;
      drop_q  <= drop_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
    end
  end

  nalsc_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_acc),
    .load_cnt_i (nres),
    .load_res_i (res),
    .take_i     (m_axis_tready),
    .head_o     (head),
    .valid_o    (q_valid),
    .can_load_o (q_can_load)
  );

  // Drive the result stream from the queue head
  assign m_axis_tvalid = q_valid;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tdata  = {{PadW{1'b0}}, head.length_saturated, head.unit_length,
                          head.unit_type, head.first_of_unit, head.payload_byte};

endmodule
